// ----- rtl/otrb_pkg.sv -----
// shared types, constants and helpers for the overwriting trace ring buffer
package otrb_pkg;

  // ring geometry
  localparam int TRACE_DEPTH = 32;
  localparam int IDX_W       = $clog2(TRACE_DEPTH);
  localparam int CNT_W       = $clog2(TRACE_DEPTH + 1);
  localparam int SUM_W       = CNT_W + 1;

  // request codes
  localparam logic [1:0] REQ_RECORD    = 2'd0;
  localparam logic [1:0] REQ_TRACE_ON  = 2'd1;
  localparam logic [1:0] REQ_TRACE_OFF = 2'd2;
  localparam logic [1:0] REQ_DRAIN     = 2'd3;

  // result kinds
  localparam logic [1:0] KIND_STATUS  = 2'd0;
  localparam logic [1:0] KIND_EVENT   = 2'd1;
  localparam logic [1:0] KIND_SUMMARY = 2'd2;

  // one recorded action as it comes in
  typedef struct packed {
    logic        boundary;
    logic [15:0] action_kind;
    logic [7:0]  player_num;
    logic [31:0] tick;
    logic [31:0] data1;
    logic [31:0] data2;
    logic [31:0] data3;
  } evt_t;

  // one ring entry: sequence stamp plus the event
  typedef struct packed {
    logic [31:0] sequence_num;
    evt_t        evt;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // result beat control, aligned with the ram read data
  typedef struct packed {
    logic        valid;
    logic [1:0]  kind;
    logic        tracing;
    logic        last;
    logic [31:0] dropped;
  } res_ctl_t;

  // ring index advance with wrap
  function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] idx);
    logic [IDX_W-1:0] nxt;
    if (idx == IDX_W'(TRACE_DEPTH - 1)) begin
      nxt = '0;
    end else begin
      nxt = idx + IDX_W'(1);
    end
    return nxt;
  endfunction

endpackage

// ----- rtl/otrb_ram.sv -----
// generic single write port ram with registered read
module otrb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/otrb_ctrl.sv -----
// ring pointers, counters and drain sequencer of the trace buffer
module otrb_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [1:0]                 req_type,
  input  otrb_pkg::evt_t             evt,
  output logic                       busy,
  output logic                       wr_en,
  output logic [otrb_pkg::IDX_W-1:0] wr_addr,
  output otrb_pkg::entry_t           wr_data,
  output logic                       rd_en,
  output logic [otrb_pkg::IDX_W-1:0] rd_addr,
  output otrb_pkg::res_ctl_t         res
);
  import otrb_pkg::*;

  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_DRAIN = 1'b1;

  logic             state;
  logic             trace_enabled;
  logic [IDX_W-1:0] oldest;
  logic [CNT_W-1:0] entry_count;
  logic [31:0]      dropped;
  logic [31:0]      seq_count;
  logic [IDX_W-1:0] rd_ptr;
  logic [CNT_W-1:0] remaining;

  logic             accept;
  logic             full;
  logic             rec;
  logic [SUM_W-1:0] slot_sum;
  logic [SUM_W-1:0] slot_wrap;
  res_ctl_t         res_next;

  assign busy   = (state == ST_DRAIN);
  assign accept = start && !busy;
  assign full   = (entry_count == CNT_W'(TRACE_DEPTH));
  assign rec    = accept && (req_type == REQ_RECORD) && trace_enabled;

  // next free slot: oldest plus count, folded once into the ring
  assign slot_sum  = SUM_W'(oldest) + SUM_W'(entry_count);
  assign slot_wrap = (slot_sum >= SUM_W'(TRACE_DEPTH)) ?
                     slot_sum - SUM_W'(TRACE_DEPTH) : slot_sum;

  // write side: a full ring reuses the oldest slot
  assign wr_en   = rec;
  assign wr_addr = full ? oldest : slot_wrap[IDX_W-1:0];
  assign wr_data = '{sequence_num: seq_count + 32'd1, evt: evt};

  // read side: only while draining, so no write can hit the same entry
  assign rd_en   = (state == ST_DRAIN) && (remaining != '0);
  assign rd_addr = rd_ptr;

  // result beat for the next cycle
  always_comb begin
    res_next = '0;
    case (state)
      ST_IDLE: begin
        if (accept && (req_type == REQ_TRACE_ON || req_type == REQ_TRACE_OFF)) begin
          res_next.valid   = 1'b1;
          res_next.kind    = KIND_STATUS;
          res_next.tracing = (req_type == REQ_TRACE_ON);
          res_next.last    = 1'b1;
        end
      end
      ST_DRAIN: begin
        // read issued now, beat goes out with the read data
        res_next.valid = 1'b1;
        if (remaining != '0) begin
          res_next.kind = KIND_EVENT;
        end else begin
          res_next.kind    = KIND_SUMMARY;
          res_next.last    = 1'b1;
          res_next.dropped = dropped;
        end
      end
      default: begin
      end
    endcase
  end

  // sequencer and ring state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      trace_enabled <= 1'b0;
      oldest        <= '0;
      entry_count   <= '0;
      dropped       <= '0;
      seq_count     <= '0;
      rd_ptr        <= '0;
      remaining     <= '0;
      res           <= '0;
    end else begin
      res <= res_next;
      case (state)
        ST_IDLE: begin
          if (accept) begin
            case (req_type)
              REQ_RECORD: begin
                if (trace_enabled) begin
                  seq_count <= seq_count + 32'd1;
                  if (full) begin
                    oldest <= idx_inc(oldest);
                    if (dropped != '1) begin
                      dropped <= dropped + 32'd1;
                    end
                  end else begin
                    entry_count <= entry_count + CNT_W'(1);
                  end
                end
              end
              REQ_TRACE_ON, REQ_TRACE_OFF: begin
                trace_enabled <= (req_type == REQ_TRACE_ON);
              end
              REQ_DRAIN: begin
                state     <= ST_DRAIN;
                rd_ptr    <= oldest;
                remaining <= entry_count;
              end
              default: begin
              end
            endcase
          end
        end
        ST_DRAIN: begin
          if (remaining != '0) begin
            remaining <= remaining - CNT_W'(1);
            rd_ptr    <= idx_inc(rd_ptr);
          end else begin
            entry_count <= '0;
            oldest      <= '0;
            dropped     <= '0;
            state       <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CNT_W'(TRACE_DEPTH))
    else $error("entry count beyond ring depth");

  a_summary_ends_drain: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DRAIN && remaining == '0) |=>
      (res.valid && res.kind == KIND_SUMMARY && res.last && state == ST_IDLE))
    else $error("drain did not end with a summary beat");

  a_event_not_last: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.kind == KIND_EVENT) |-> !res.last)
    else $error("event beat marked last");

  a_no_write_in_drain: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (state == ST_IDLE && !rd_en))
    else $error("ring write during drain");

endmodule

// ----- rtl/overwriting_trace_ring_buffer.sv -----
// top level of the overwriting trace ring buffer: ring ram, control and result formatting
//
// Usage:
//   A request beat is taken at a rising edge with start high and busy low.
//   req_type selects record, trace on, trace off or drain; the event fields
//   matter only for a record.
//   Record: written into the ring in the accept cycle, no result beat; one
//   record per cycle is sustained while no drain holds busy high. A full
//   ring overwrites its oldest entry and bumps the saturating drop count.
//   Trace on/off: one status beat, marked last, in the cycle after accept;
//   busy stays low, so a new request can follow at once.
//   Drain: busy goes high after accept. The N stored entries (0..32) come
//   out as event beats, one per cycle, oldest first: the ring ram read
//   register supplies each event, aligned with the registered result control;
//   then comes a summary beat carrying the drop count and
//   marked last, in the cycle where busy is low again.
//   Each result beat is on the ports for exactly one cycle with valid high;
//   the receiver must take it, there is no back pressure.
//   Reset (rst, synchronous) turns tracing off and empties the ring; the ram
//   contents are not cleared and need no clearing pass.
module overwriting_trace_ring_buffer (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  req_type,
  input  logic        boundary,
  input  logic [31:0] tick,
  input  logic [15:0] action_kind,
  input  logic [7:0]  player_num,
  input  logic [31:0] data1,
  input  logic [31:0] data2,
  input  logic [31:0] data3,
  output logic        valid,
  output logic [1:0]  result_kind,
  output logic        out_tracing,
  output logic [31:0] out_sequence,
  output logic        out_boundary,
  output logic [31:0] out_tick,
  output logic [15:0] out_action_kind,
  output logic [7:0]  out_player_num,
  output logic [31:0] out_data1,
  output logic [31:0] out_data2,
  output logic [31:0] out_data3,
  output logic [31:0] out_dropped,
  output logic        last
);
  import otrb_pkg::*;

  evt_t             evt;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  entry_t           wr_data;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic [ENTRY_W-1:0] rd_bits;
  entry_t           rd_entry;
  res_ctl_t         res;
  logic             is_event;

  // pack the incoming event
  assign evt = '{boundary: boundary, action_kind: action_kind, player_num: player_num,
                 tick: tick, data1: data1, data2: data2, data3: data3};

  otrb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .req_type (req_type),
    .evt      (evt),
    .busy     (busy),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .res      (res)
  );

  otrb_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TRACE_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_bits)
  );

  assign rd_entry = rd_bits;

  // result beat: event fields from the ram, zero for other kinds
  assign is_event        = res.valid && (res.kind == KIND_EVENT);
  assign valid           = res.valid;
  assign result_kind     = res.kind;
  assign out_tracing     = res.tracing;
  assign out_dropped     = res.dropped;
  assign last            = res.last;
  assign out_sequence    = is_event ? rd_entry.sequence_num    : '0;
  assign out_boundary    = is_event ? rd_entry.evt.boundary    : 1'b0;
  assign out_tick        = is_event ? rd_entry.evt.tick        : '0;
  assign out_action_kind = is_event ? rd_entry.evt.action_kind : '0;
  assign out_player_num  = is_event ? rd_entry.evt.player_num  : '0;
  assign out_data1       = is_event ? rd_entry.evt.data1       : '0;
  assign out_data2       = is_event ? rd_entry.evt.data2       : '0;
  assign out_data3       = is_event ? rd_entry.evt.data3       : '0;

endmodule

// ----- tb/trace_ring_checker.sv -----
// checker for the trace ring buffer: predicts every result beat and compares it with the DUT
module trace_ring_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  req_type,
  input  logic        boundary,
  input  logic [31:0] tick,
  input  logic [15:0] action_kind,
  input  logic [7:0]  player_num,
  input  logic [31:0] data1,
  input  logic [31:0] data2,
  input  logic [31:0] data3,
  input  logic        valid,
  input  logic [1:0]  result_kind,
  input  logic        out_tracing,
  input  logic [31:0] out_sequence,
  input  logic        out_boundary,
  input  logic [31:0] out_tick,
  input  logic [15:0] out_action_kind,
  input  logic [7:0]  out_player_num,
  input  logic [31:0] out_data1,
  input  logic [31:0] out_data2,
  input  logic [31:0] out_data3,
  input  logic [31:0] out_dropped,
  input  logic        last,
  output int          failures,
  output int          pending,
  output int          beats_checked,
  output int          drains_seen,
  output int          events_kept,
  output int          overwrites
);
  import otrb_pkg::*;

  // one result beat as it appears on the output ports
  typedef struct packed {
    logic [1:0]  kind;
    logic        tracing;
    logic [31:0] sequence_num;
    logic        boundary;
    logic [31:0] tick;
    logic [15:0] action_kind;
    logic [7:0]  player_num;
    logic [31:0] data1;
    logic [31:0] data2;
    logic [31:0] data3;
    logic [31:0] dropped;
    logic        last;
  } trace_beat_t;

  trace_beat_t expected_beats[$];

  // shadow copy of the ring and its control state
  entry_t      ring_copy [TRACE_DEPTH];
  logic        shadow_tracing;
  int          shadow_oldest;
  int          shadow_count;
  logic [31:0] shadow_dropped;
  logic [31:0] shadow_seq;

  int n_fail   = 0;
  int n_beats  = 0;
  int n_drains = 0;
  int n_kept   = 0;
  int n_over   = 0;

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    n_fail++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s is %h, should be %h", name, got, want));
    end
  endtask

  function automatic trace_beat_t blank_beat();
    trace_beat_t b;
    b = '0;
    return b;
  endfunction

  // advance the shadow state by one accepted request beat
  task automatic predict_request(input logic [1:0] req, input evt_t ev);
    trace_beat_t b;
    int          slot;
    case (req)
      REQ_RECORD: begin
        if (shadow_tracing) begin
          // full ring: drop the oldest, drop count saturates
          if (shadow_count >= TRACE_DEPTH) begin
            shadow_oldest = (shadow_oldest + 1) % TRACE_DEPTH;
            shadow_count  = TRACE_DEPTH - 1;
            if (shadow_dropped != 32'hFFFF_FFFF) begin
              shadow_dropped = shadow_dropped + 1;
            end
            n_over++;
          end
          slot = (shadow_oldest + shadow_count) % TRACE_DEPTH;
          shadow_count++;
          shadow_seq = shadow_seq + 1;
          ring_copy[slot].sequence_num = shadow_seq;
          ring_copy[slot].evt          = ev;
          n_kept++;
        end
      end
      REQ_TRACE_ON, REQ_TRACE_OFF: begin
        shadow_tracing = (req == REQ_TRACE_ON);
        b = blank_beat();
        b.kind    = KIND_STATUS;
        b.tracing = shadow_tracing;
        b.last    = 1'b1;
        expected_beats.push_back(b);
      end
      default: begin
        // drain: stored events oldest first, then the summary
        for (int i = 0; i < shadow_count; i++) begin
          slot = (shadow_oldest + i) % TRACE_DEPTH;
          b = blank_beat();
          b.kind         = KIND_EVENT;
          b.sequence_num = ring_copy[slot].sequence_num;
          b.boundary     = ring_copy[slot].evt.boundary;
          b.tick         = ring_copy[slot].evt.tick;
          b.action_kind  = ring_copy[slot].evt.action_kind;
          b.player_num   = ring_copy[slot].evt.player_num;
          b.data1        = ring_copy[slot].evt.data1;
          b.data2        = ring_copy[slot].evt.data2;
          b.data3        = ring_copy[slot].evt.data3;
          expected_beats.push_back(b);
        end
        b = blank_beat();
        b.kind    = KIND_SUMMARY;
        b.dropped = shadow_dropped;
        b.last    = 1'b1;
        expected_beats.push_back(b);
        shadow_count   = 0;
        shadow_oldest  = 0;
        shadow_dropped = '0;
        n_drains++;
      end
    endcase
  endtask

  // watch both channels at every rising edge
  always @(posedge clk) begin : watch
    trace_beat_t got;
    trace_beat_t want;
    evt_t        ev;
    if (rst) begin
      shadow_tracing = 1'b0;
      shadow_oldest  = 0;
      shadow_count   = 0;
      shadow_dropped = '0;
      shadow_seq     = '0;
      expected_beats.delete();
    end else begin
      // result side: compare with the oldest expectation
      if (valid) begin
        got.kind         = result_kind;
        got.tracing      = out_tracing;
        got.sequence_num = out_sequence;
        got.boundary     = out_boundary;
        got.tick         = out_tick;
        got.action_kind  = out_action_kind;
        got.player_num   = out_player_num;
        got.data1        = out_data1;
        got.data2        = out_data2;
        got.data3        = out_data3;
        got.dropped      = out_dropped;
        got.last         = last;
        if (expected_beats.size() == 0) begin
          report_mismatch("result beat with nothing expected");
        end else begin
          want = expected_beats.pop_front();
          check_field("result_kind", 32'(got.kind), 32'(want.kind));
          check_field("out_tracing", 32'(got.tracing), 32'(want.tracing));
          check_field("out_sequence", got.sequence_num, want.sequence_num);
          check_field("out_boundary", 32'(got.boundary), 32'(want.boundary));
          check_field("out_tick", got.tick, want.tick);
          check_field("out_action_kind", 32'(got.action_kind), 32'(want.action_kind));
          check_field("out_player_num", 32'(got.player_num), 32'(want.player_num));
          check_field("out_data1", got.data1, want.data1);
          check_field("out_data2", got.data2, want.data2);
          check_field("out_data3", got.data3, want.data3);
          check_field("out_dropped", got.dropped, want.dropped);
          check_field("last", 32'(got.last), 32'(want.last));
        end
        n_beats++;
      end
      // request side: a beat is taken when start is high and busy low
      if (start && !busy) begin
        ev.boundary    = boundary;
        ev.action_kind = action_kind;
        ev.player_num  = player_num;
        ev.tick        = tick;
        ev.data1       = data1;
        ev.data2       = data2;
        ev.data3       = data3;
        predict_request(req_type, ev);
      end
    end
    failures      <= n_fail;
    pending       <= expected_beats.size();
    beats_checked <= n_beats;
    drains_seen   <= n_drains;
    events_kept   <= n_kept;
    overwrites    <= n_over;
  end

endmodule

// ----- tb/tb_overwriting_trace_ring_buffer.sv -----
// testbench top for the overwriting trace ring buffer: clock, reset, request stimulus, verdict
module tb_overwriting_trace_ring_buffer;
  import otrb_pkg::*;

  localparam int CYCLE_LIMIT  = 100000;
  localparam int RANDOM_ITEMS = 150;
  localparam int DRAIN_TAIL   = 40;

  logic        clk         = 1'b0;
  logic        rst         = 1'b1;
  logic        start       = 1'b0;
  logic [1:0]  req_type    = REQ_RECORD;
  logic        boundary    = 1'b0;
  logic [31:0] tick        = '0;
  logic [15:0] action_kind = '0;
  logic [7:0]  player_num  = '0;
  logic [31:0] data1       = '0;
  logic [31:0] data2       = '0;
  logic [31:0] data3       = '0;

  logic        busy;
  logic        valid;
  logic [1:0]  result_kind;
  logic        out_tracing;
  logic [31:0] out_sequence;
  logic        out_boundary;
  logic [31:0] out_tick;
  logic [15:0] out_action_kind;
  logic [7:0]  out_player_num;
  logic [31:0] out_data1;
  logic [31:0] out_data2;
  logic [31:0] out_data3;
  logic [31:0] out_dropped;
  logic        last;

  int failures;
  int pending;
  int beats_checked;
  int drains_seen;
  int events_kept;
  int overwrites;

  int   cycles     = 0;
  int   items      = 0;
  int   burst_left = 4;
  logic tracing_on = 1'b0;

  always #4 clk = ~clk;

  overwriting_trace_ring_buffer DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .req_type(req_type), .boundary(boundary), .tick(tick),
    .action_kind(action_kind), .player_num(player_num),
    .data1(data1), .data2(data2), .data3(data3),
    .valid(valid), .result_kind(result_kind), .out_tracing(out_tracing),
    .out_sequence(out_sequence), .out_boundary(out_boundary), .out_tick(out_tick),
    .out_action_kind(out_action_kind), .out_player_num(out_player_num),
    .out_data1(out_data1), .out_data2(out_data2), .out_data3(out_data3),
    .out_dropped(out_dropped), .last(last)
  );

  trace_ring_checker ring_check (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .req_type(req_type), .boundary(boundary), .tick(tick),
    .action_kind(action_kind), .player_num(player_num),
    .data1(data1), .data2(data2), .data3(data3),
    .valid(valid), .result_kind(result_kind), .out_tracing(out_tracing),
    .out_sequence(out_sequence), .out_boundary(out_boundary), .out_tick(out_tick),
    .out_action_kind(out_action_kind), .out_player_num(out_player_num),
    .out_data1(out_data1), .out_data2(out_data2), .out_data3(out_data3),
    .out_dropped(out_dropped), .last(last),
    .failures(failures), .pending(pending), .beats_checked(beats_checked),
    .drains_seen(drains_seen), .events_kept(events_kept), .overwrites(overwrites)
  );

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // payload word, biased toward all zeros and all ones
  function automatic logic [31:0] pick_word();
    logic [31:0] w;
    case ($urandom_range(0, 7))
      0:       w = '0;
      1:       w = '1;
      default: w = $urandom;
    endcase
    return w;
  endfunction

  // drive one request beat, wait for it to be taken, then pace the sender
  task automatic send_req(input logic [1:0] req, input logic bnd, input logic [31:0] tk,
                          input logic [15:0] act, input logic [7:0] pid,
                          input logic [31:0] w1, input logic [31:0] w2,
                          input logic [31:0] w3);
    req_type    <= req;
    boundary    <= bnd;
    tick        <= tk;
    action_kind <= act;
    player_num  <= pid;
    data1       <= w1;
    data2       <= w2;
    data3       <= w3;
    start       <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    // records dropped while tracing is off do not count
    if (req != REQ_RECORD || tracing_on) begin
      items++;
    end
    if (req == REQ_TRACE_ON) begin
      tracing_on = 1'b1;
    end else if (req == REQ_TRACE_OFF) begin
      tracing_on = 1'b0;
    end
    // bursts of back to back beats with random gaps between them
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? 60 : $urandom_range(0, 12);
    end
  endtask

  task automatic send_rand(input logic [1:0] req);
    send_req(req, 1'($urandom_range(0, 1)), pick_word(), 16'(pick_word()),
             8'(pick_word()), pick_word(), pick_word(), pick_word());
  endtask

  initial begin : stimulus
    int goal;
    int seq_no;
    int choice;
    int n;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: empty drain, ignored record, status, field extremes
    send_rand(REQ_DRAIN);
    send_rand(REQ_RECORD);
    send_rand(REQ_TRACE_OFF);
    send_rand(REQ_TRACE_ON);
    send_rand(REQ_TRACE_ON);
    send_req(REQ_RECORD, 1'b0, '0, '0, '0, '0, '0, '0);
    send_req(REQ_RECORD, 1'b1, '1, '1, '1, '1, '1, '1);
    send_req(REQ_RECORD, 1'b1, 32'hAAAA_AAAA, 16'h5555, 8'hA5,
             32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F);
    send_rand(REQ_DRAIN);
    send_rand(REQ_DRAIN);
    send_rand(REQ_TRACE_OFF);
    send_rand(REQ_RECORD);
    send_rand(REQ_TRACE_ON);
    send_rand(REQ_RECORD);
    send_rand(REQ_TRACE_OFF);
    send_rand(REQ_DRAIN);

    // random: mostly on / records / drain sequences, some noise
    goal   = items + RANDOM_ITEMS;
    seq_no = 0;
    while (items < goal) begin
      choice = $urandom_range(0, 9);
      if (choice < 7) begin
        send_rand(REQ_TRACE_ON);
        // the first sequence always wraps the ring
        if (seq_no == 0 || $urandom_range(0, 4) == 0) begin
          n = $urandom_range(33, 45);
        end else begin
          n = $urandom_range(0, 8);
        end
        repeat (n) send_rand(REQ_RECORD);
        if ($urandom_range(0, 2) == 0) begin
          send_rand(REQ_TRACE_OFF);
          repeat ($urandom_range(0, 3)) send_rand(REQ_RECORD);
        end
        // sometimes leave the ring filled into the next sequence
        if ($urandom_range(0, 4) != 0) begin
          send_rand(REQ_DRAIN);
        end
      end else if (choice < 9) begin
        send_rand(2'($urandom_range(0, 3)));
      end else begin
        send_rand(REQ_DRAIN);
        send_rand(REQ_DRAIN);
      end
      seq_no++;
    end

    // wind down: let every expected beat arrive, then a tail for strays
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_TAIL) @(posedge clk);

    $display("covered %0d requests: %0d drains, %0d events kept, %0d overwritten",
             items, drains_seen, events_kept, overwrites);
    $display("compared %0d result beats, %0d mismatches", beats_checked, failures);
    if (failures == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
